FILE: src/sdq_pkg.sv
// package for the sorted deadline queue: command and status codes, controller states
// no dependencies
`timescale 1ns / 1ps

package sdq_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SET_DUE = 3'd2,
        CMD_SET_DONE = 3'd3,
        CMD_LOOKUP = 3'd4
    } cmd_t;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REINSERT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input fields
        logic exec;      // first step: match and act
        logic reinsert;  // second step of set-due
        logic out_load;  // register the result
    } sdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_reinsert;
    } sdq_stat_t;

endpackage

FILE: src/sorted_deadline_queue.sv
// Sorted deadline queue: up to DEPTH entries kept in ascending due-key order in a chain
// of slots that all compare against the request at once. Each command is taken in an
// accepting cycle (ST_IDLE), then does its compare-and-shift in ST_OUT, where its result
// is registered for the output; a set-due command goes on to ST_REINSERT and registers
// its result there, since its remove shift and insert shift use the slot chain in turn.
// A result still waiting on m_tready holds the next command in its compare cycle.
// One command is in flight at a time. entry_count reflects the table after the command.
`timescale 1ns / 1ps

module sorted_deadline_queue
    import sdq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int ID_BITS = 32,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[2:0], entry_id[34:3], due_date[66:35], done_flag[67]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], found_due[33:2], found_done[34], entry_count[41:35]
);

    sdq_cmd_t  cmd;
    sdq_stat_t stat;
    logic [1:0]  res_status;
    logic [31:0] res_due;
    logic        res_done;
    logic [6:0]  res_count;

    sdq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    sdq_datapath #(.DEPTH(DEPTH), .ID_BITS(ID_BITS), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_cmd(s_tdata[2:0]), .in_id(s_tdata[34:3]), .in_due(s_tdata[66:35]),
        .in_done(s_tdata[67]),
        .res_status(res_status), .res_due(res_due), .res_done(res_done),
        .res_count(res_count)
    );

    assign m_tdata = {6'd0, res_count, res_done, res_due, res_status};

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[41:35] <= 7'(DEPTH)))
        else $error("entry count beyond depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted while busy");
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == STATUS_FULL) |-> (m_tdata[41:35] == 7'(DEPTH)))
        else $error("full status without full table");

endmodule

FILE: src/sdq_ctrl.sv
// controller state machine for the sorted deadline queue
// depends on sdq_pkg
`timescale 1ns / 1ps

module sdq_ctrl
    import sdq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  sdq_stat_t stat,
    output sdq_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // exec step once the output register is free; result goes to it unless set-due needs a reinsert
                if (!out_valid_reg || out_ready) begin
                    cmd.exec = 1'b1;
                    if (stat.need_reinsert) begin
                        state_next = ST_REINSERT;
                    end else begin
                        cmd.out_load = 1'b1;
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REINSERT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.reinsert = 1'b1;
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: src/sdq_datapath.sv
// datapath: a chain of slots kept sorted by due key, with all-slot compare
// depends on sdq_pkg
`timescale 1ns / 1ps

module sdq_datapath
    import sdq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int ID_BITS = 32,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  sdq_cmd_t    cmd,
    output sdq_stat_t   stat,
    input  logic [2:0]  in_cmd,
    input  logic [31:0] in_id,
    input  logic [31:0] in_due,
    input  logic        in_done,
    output logic [1:0]  res_status,
    output logic [31:0] res_due,
    output logic        res_done,
    output logic [6:0]  res_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic [IW-1:0] slot_id_reg [DEPTH];
    logic [KW-1:0] slot_due_reg [DEPTH];
    logic          slot_done_reg [DEPTH];
    logic [CW-1:0] used_count_reg, used_count_next;

    logic [2:0]    op_reg;
    logic [IW-1:0] id_reg;
    logic [KW-1:0] due_reg;
    logic          done_reg;
    logic          keep_reg;

    logic [1:0]    status_reg;
    logic [31:0]   rdue_reg;
    logic          rdone_reg;

    logic [DEPTH-1:0] valid_v, match_v, first_v, after_v, later_v, ins_v, right_v;
    logic          found;
    logic [KW-1:0] hit_due;
    logic          hit_done;
    logic          is_ins, is_del, is_full;
    logic [KW-1:0] ins_due;
    logic          ins_done;
    logic [1:0]    status_c;
    logic [KW-1:0] rdue_c;
    logic          rdone_c;

    // one compare per slot, then a prefix chain for first match / insert point
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_v[i] = CW'(i) < used_count_reg;
            match_v[i] = valid_v[i] && (slot_id_reg[i] == id_reg);
            later_v[i] = valid_v[i] && !(slot_due_reg[i] < ins_due);
        end
        first_v[0] = match_v[0];
        after_v[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++) begin
            after_v[i] = after_v[i-1] | match_v[i-1];
            first_v[i] = match_v[i] & ~after_v[i];
        end
        // right_v: slots at or beyond the insert point (inserted ones shift up)
        right_v[0] = later_v[0] | ~valid_v[0];
        for (int i = 1; i < DEPTH; i++) right_v[i] = right_v[i-1] | later_v[i] | ~valid_v[i];
        ins_v[0] = right_v[0];
        for (int i = 1; i < DEPTH; i++) ins_v[i] = right_v[i] & ~right_v[i-1];
        found = |match_v;
        hit_due = '0;
        hit_done = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_v[i]) begin
                hit_due = slot_due_reg[i];
                hit_done = slot_done_reg[i];
            end
        end
    end

    assign is_full = used_count_reg == CW'(DEPTH);
    assign ins_due = cmd.reinsert ? due_reg : due_reg;
    assign ins_done = cmd.reinsert ? keep_reg : done_reg;
    assign is_ins = (cmd.exec && op_reg == CMD_INSERT && !is_full) || cmd.reinsert;
    assign is_del = cmd.exec && found && (op_reg == CMD_REMOVE || op_reg == CMD_SET_DUE);
    assign stat.need_reinsert = (op_reg == CMD_SET_DUE) && found;

    always_comb begin
        status_c = STATUS_OK;
        rdue_c = '0;
        rdone_c = 1'b0;
        used_count_next = used_count_reg;
        if (cmd.reinsert) begin
            rdue_c = due_reg;
            rdone_c = keep_reg;
            used_count_next = used_count_reg + 1'b1;
        end else begin
            unique case (op_reg)
                CMD_INSERT: begin
                    if (is_full) status_c = STATUS_FULL;
                    else begin
                        rdue_c = due_reg;
                        rdone_c = done_reg;
                        used_count_next = used_count_reg + 1'b1;
                    end
                end
                CMD_REMOVE, CMD_SET_DUE, CMD_SET_DONE, CMD_LOOKUP: begin
                    if (!found) status_c = STATUS_NOT_FOUND;
                    else begin
                        rdue_c = hit_due;
                        rdone_c = (op_reg == CMD_SET_DONE) ? done_reg : hit_done;
                        if (op_reg != CMD_SET_DONE && op_reg != CMD_LOOKUP)
                            used_count_next = used_count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) used_count_reg <= '0;
        else if (cmd.exec || cmd.reinsert) used_count_reg <= used_count_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_cmd;
            id_reg <= in_id[IW-1:0];
            due_reg <= in_due[KW-1:0];
            done_reg <= in_done;
        end
        if (cmd.exec) keep_reg <= hit_done;
        if (cmd.out_load) begin
            status_reg <= status_c;
            rdue_reg <= 32'(rdue_c);
            rdone_reg <= rdone_c;
        end
        // slot shifts: insert moves right part up, delete moves tail down; set-done rewrites one flag
        for (int i = 0; i < DEPTH; i++) begin
            if (is_ins) begin
                if (ins_v[i]) begin
                    slot_id_reg[i] <= id_reg;
                    slot_due_reg[i] <= ins_due;
                    slot_done_reg[i] <= ins_done;
                end else if (right_v[i] && i > 0) begin
                    slot_id_reg[i] <= slot_id_reg[(i > 0) ? i-1 : 0];
                    slot_due_reg[i] <= slot_due_reg[(i > 0) ? i-1 : 0];
                    slot_done_reg[i] <= slot_done_reg[(i > 0) ? i-1 : 0];
                end
            end else if (is_del) begin
                if ((first_v[i] || after_v[i]) && i < DEPTH - 1) begin
                    slot_id_reg[i] <= slot_id_reg[(i < DEPTH-1) ? i+1 : i];
                    slot_due_reg[i] <= slot_due_reg[(i < DEPTH-1) ? i+1 : i];
                    slot_done_reg[i] <= slot_done_reg[(i < DEPTH-1) ? i+1 : i];
                end
            end else if (cmd.exec && op_reg == CMD_SET_DONE && first_v[i]) begin
                slot_done_reg[i] <= done_reg;
            end
        end
    end

    assign res_status = status_reg;
    assign res_due = rdue_reg;
    assign res_done = rdone_reg;
    assign res_count = 7'(used_count_reg);

endmodule

FILE: tb/tb.sv
// testbench for sorted_deadline_queue: directed and random commands, scoreboard in a class
// depends on sdq_pkg and the sorted_deadline_queue rtl
`timescale 1ns / 1ps

module tb;
    import sdq_pkg::*;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] due;
        logic        done;
        logic [6:0]  count;
    } reply_t;

    class deadline_scoreboard;
        logic [31:0] ids[$];
        logic [31:0] dues[$];
        logic        dones[$];
        reply_t      pending[$];
        int          mismatches;

        function int find_id(logic [31:0] id);
            for (int i = 0; i < ids.size(); i++) begin
                if (ids[i] == id) return i;
            end
            return -1;
        endfunction

        function void place(logic [31:0] id, logic [31:0] due, logic done);
            int pos;
            pos = 0;
            while (pos < dues.size() && dues[pos] < due) pos++;
            ids.insert(pos, id);
            dues.insert(pos, due);
            dones.insert(pos, done);
        endfunction

        function void note_command(logic [2:0] cmd, logic [31:0] id, logic [31:0] due,
                                   logic done);
            reply_t r;
            int pos;
            logic keep;
            r.status = STATUS_OK;
            r.due = '0;
            r.done = 1'b0;
            if (cmd == CMD_INSERT) begin
                if (ids.size() >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    place(id, due, done);
                    r.due = due;
                    r.done = done;
                end
            end else if (cmd >= CMD_REMOVE && cmd <= CMD_LOOKUP) begin
                pos = find_id(id);
                if (pos < 0) begin
                    r.status = STATUS_NOT_FOUND;
                end else if (cmd == CMD_REMOVE) begin
                    r.due = dues[pos];
                    r.done = dones[pos];
                    ids.delete(pos);
                    dues.delete(pos);
                    dones.delete(pos);
                end else if (cmd == CMD_SET_DUE) begin
                    keep = dones[pos];
                    ids.delete(pos);
                    dues.delete(pos);
                    dones.delete(pos);
                    place(id, due, keep);
                    r.due = due;
                    r.done = keep;
                end else if (cmd == CMD_SET_DONE) begin
                    dones[pos] = done;
                    r.due = dues[pos];
                    r.done = done;
                end else begin
                    r.due = dues[pos];
                    r.done = dones[pos];
                end
            end
            r.count = 7'(ids.size());
            pending.push_back(r);
        endfunction

        function void check_reply(logic [47:0] data);
            reply_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[1:0] !== e.status || data[33:2] !== e.due || data[34] !== e.done
                    || data[41:35] !== e.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp status %0d due %h done %b count %0d,",
                              " got status %0d due %h done %b count %0d"},
                             e.status, e.due, e.done, e.count,
                             data[1:0], data[33:2], data[34], data[41:35]);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;

    deadline_scoreboard board;
    int idle_cycles = 0;
    bit stimulus_done;
    logic [31:0] used_ids[$];

    always #5 aclk = ~aclk;

    sorted_deadline_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_command(logic [2:0] cmd, logic [31:0] id, logic [31:0] due,
                                logic done);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, done, due, id, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(cmd, id, due, done);
        if (cmd == CMD_INSERT) used_ids.push_back(id);
        repeat (gap_length()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(0, 9) < 8)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_due();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, result checked on every accepted transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_reply(m_tdata);
            m_tready <= ($urandom_range(0, 99) < 70) || stimulus_done
                        ? ($urandom_range(0, 99) < 97) : 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int hi;
        int r;
        logic [2:0] c;
        board = new();
        stimulus_done = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table misses, extremes, equal keys, every command
        send_command(CMD_LOOKUP, 32'h0, 32'h0, 1'b0);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_command(CMD_INSERT, 32'h0, 32'h0, 1'b0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_INSERT, 32'h5, 32'h100, 1'b0);
        send_command(CMD_INSERT, 32'h6, 32'h100, 1'b1);
        send_command(CMD_INSERT, 32'h5, 32'h80, 1'b1);
        send_command(CMD_LOOKUP, 32'h5, 32'h0, 1'b0);
        send_command(CMD_SET_DONE, 32'h6, 32'h0, 1'b0);
        send_command(CMD_SET_DUE, 32'h5, 32'hFFFF_FFFF, 1'b0);
        send_command(CMD_SET_DUE, 32'h7, 32'h1, 1'b0);
        send_command(CMD_SET_DONE, 32'h7, 32'h1, 1'b1);
        send_command(CMD_REMOVE, 32'h5, 32'h0, 1'b0);
        send_command(CMD_LOOKUP, 32'h5, 32'h0, 1'b0);
        send_command(3'd5, 32'h6, 32'h1, 1'b1);
        send_command(3'd6, 32'h0, 32'h0, 1'b0);
        send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_command(CMD_REMOVE, 32'h0, 32'h0, 1'b0);

        // random phases alternating fill-heavy and drain-heavy mixes
        for (int i = 0; i < 1700; i++) begin
            hi = ((i / 200) % 2 == 0) ? 65 : 25;
            r = $urandom_range(0, 99);
            if (r < hi) c = CMD_INSERT;
            else if (r < 96) c = 3'($urandom_range(CMD_REMOVE, CMD_LOOKUP));
            else c = 3'($urandom_range(5, 7));
            send_command(c, c == CMD_INSERT && $urandom_range(0, 3) == 0 ? $urandom : pick_id(),
                         pick_due(), 1'($urandom));
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1;

        while (board.pending.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
